[sv/kmh_pkg.sv]
// Package for the k-way merge head list: payload structs, controller/datapath
// command and status types, register indexes and field widths.
// No dependencies.
package kmh_pkg;

    localparam int MAX_STREAMS_DEF = 8;
    localparam int KEY_WIDTH       = 32;
    localparam int SRC_W           = 3;
    localparam int LEN_W           = 16;
    localparam int SCOUNT_W        = 4;
    localparam int BYTE_LIMIT_W    = 32;
    localparam int ROW_LIMIT_W     = 16;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_BYTE_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_ROW_LIMIT  = 2'd2;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_END    = 1'b1;

    localparam logic [SCOUNT_W-1:0]     STREAM_COUNT_RST = 4'd8;
    localparam logic [BYTE_LIMIT_W-1:0] BYTE_LIMIT_RST   = '1;
    localparam logic [ROW_LIMIT_W-1:0]  ROW_LIMIT_RST    = '1;

    typedef struct packed {
        logic [SRC_W-1:0]     source_stream;
        logic                 run_ended;
        logic [KEY_WIDTH-1:0] sort_key;
        logic [LEN_W-1:0]     record_length;
    } t_in_item;

    typedef struct packed {
        logic                 result_kind;
        logic [SRC_W-1:0]     winner_stream;
        logic [KEY_WIDTH-1:0] winner_key;
        logic [LEN_W-1:0]     winner_length;
        logic                 step_done;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic out_free;
    } t_dp_status;

endpackage

[sv/kmh_ctrl.sv]
// Controller for the k-way merge head list: request acceptance, fill-phase
// counting and the pop sequence. Depends on kmh_pkg.
module kmh_ctrl #(
    parameter int MAX_STREAMS = kmh_pkg::MAX_STREAMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_run_ended,
    output logic                           o_in_stall,
    input  logic [kmh_pkg::SCOUNT_W-1:0]   i_stream_count,
    input  kmh_pkg::t_dp_status            i_status,
    output kmh_pkg::t_dp_cmd               o_cmd
);
    import kmh_pkg::*;

    localparam int CW = $clog2(MAX_STREAMS + 1);
    localparam int EW = ((CW > SCOUNT_W) ? CW : SCOUNT_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic            r_merging, n_merging;
    logic            accept;
    logic [EW-1:0]   sc_ext;
    logic [EW-1:0]   eff_streams;
    logic [CW-1:0]   fill_inc;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign sc_ext     = EW'(i_stream_count);
    assign fill_inc   = r_fill + CW'(1);

    always_comb begin
        if (sc_ext == '0) begin
            eff_streams = EW'(1);
        end else if (sc_ext > EW'(MAX_STREAMS)) begin
            eff_streams = EW'(MAX_STREAMS);
        end else begin
            eff_streams = sc_ext;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_merging  = r_merging;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.insert = !i_run_ended;
                    if (r_merging) begin
                        n_state = S_POP;
                    end else if (EW'(fill_inc) >= eff_streams) begin
                        n_fill    = '0;
                        n_merging = 1'b1;
                        n_state   = S_POP;
                    end else begin
                        n_fill = fill_inc;
                    end
                end
            end
            S_POP: begin
                if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.empty) begin
                        n_merging = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_merging <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_merging <= n_merging;
        end
    end

endmodule

[sv/kmh_datapath.sv]
// Datapath for the k-way merge head list: sorted head array with parallel
// compare-and-shift insert, pop, step counters and the output register.
// Depends on kmh_pkg.
module kmh_datapath #(
    parameter int MAX_STREAMS = kmh_pkg::MAX_STREAMS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kmh_pkg::t_in_item                  i_item,
    input  kmh_pkg::t_dp_cmd                   i_cmd,
    output kmh_pkg::t_dp_status                o_status,
    input  logic [kmh_pkg::BYTE_LIMIT_W-1:0]   i_byte_limit,
    input  logic [kmh_pkg::ROW_LIMIT_W-1:0]    i_row_limit,
    input  logic                               i_out_stall,
    output logic                               o_out_valid,
    output kmh_pkg::t_out_item                 o_out
);
    import kmh_pkg::*;

    localparam int CW = $clog2(MAX_STREAMS + 1);

    logic [KEY_WIDTH-1:0]    r_keys [MAX_STREAMS];
    logic [SRC_W-1:0]        r_srcs [MAX_STREAMS];
    logic [LEN_W-1:0]        r_lens [MAX_STREAMS];
    logic [KEY_WIDTH-1:0]    n_keys [MAX_STREAMS];
    logic [SRC_W-1:0]        n_srcs [MAX_STREAMS];
    logic [LEN_W-1:0]        n_lens [MAX_STREAMS];
    logic [CW-1:0]           r_count, n_count;
    logic [BYTE_LIMIT_W-1:0] r_bytes;
    logic [ROW_LIMIT_W-1:0]  r_rows;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [MAX_STREAMS-1:0]  lt;
    logic                    full;
    logic [BYTE_LIMIT_W:0]   bsum;
    logic [ROW_LIMIT_W:0]    rsum;
    logic                    done;

    assign full              = (r_count == CW'(MAX_STREAMS));
    assign o_status.empty    = (r_count == '0);
    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    always_comb begin
        for (int j = 0; j < MAX_STREAMS; j++) begin
            lt[j] = (CW'(j) < r_count) && (r_keys[j] < i_item.sort_key);
        end
    end

    always_comb begin
        n_keys  = r_keys;
        n_srcs  = r_srcs;
        n_lens  = r_lens;
        n_count = r_count;
        if (i_cmd.insert && !full) begin
            if (!lt[0]) begin
                n_keys[0] = i_item.sort_key;
                n_srcs[0] = i_item.source_stream;
                n_lens[0] = i_item.record_length;
            end
            for (int j = 1; j < MAX_STREAMS; j++) begin
                if (!lt[j]) begin
                    if (lt[j-1]) begin
                        n_keys[j] = i_item.sort_key;
                        n_srcs[j] = i_item.source_stream;
                        n_lens[j] = i_item.record_length;
                    end else begin
                        n_keys[j] = r_keys[j-1];
                        n_srcs[j] = r_srcs[j-1];
                        n_lens[j] = r_lens[j-1];
                    end
                end
            end
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop && !o_status.empty) begin
            for (int j = 0; j < MAX_STREAMS - 1; j++) begin
                n_keys[j] = r_keys[j+1];
                n_srcs[j] = r_srcs[j+1];
                n_lens[j] = r_lens[j+1];
            end
            n_count = r_count - CW'(1);
        end
    end

    assign bsum = {1'b0, r_bytes} + (BYTE_LIMIT_W+1)'(r_lens[0]);
    assign rsum = {1'b0, r_rows} + (ROW_LIMIT_W+1)'(1);
    assign done = (bsum >= {1'b0, i_byte_limit}) || (rsum >= {1'b0, i_row_limit});

    always_ff @(posedge i_clk) begin
        r_keys <= n_keys;
        r_srcs <= n_srcs;
        r_lens <= n_lens;
        if (i_cmd.pop) begin
            if (o_status.empty) begin
                r_out.result_kind   <= KIND_END;
                r_out.winner_stream <= '0;
                r_out.winner_key    <= '0;
                r_out.winner_length <= '0;
                r_out.step_done     <= 1'b0;
            end else begin
                r_out.result_kind   <= KIND_RECORD;
                r_out.winner_stream <= r_srcs[0];
                r_out.winner_key    <= r_keys[0];
                r_out.winner_length <= r_lens[0];
                r_out.step_done     <= done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bytes     <= '0;
            r_rows      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.pop) begin
                r_out_valid <= 1'b1;
                if (o_status.empty || done) begin
                    r_bytes <= '0;
                    r_rows  <= '0;
                end else begin
                    r_bytes <= bsum[BYTE_LIMIT_W-1:0];
                    r_rows  <= rsum[ROW_LIMIT_W-1:0];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[sv/kway_merge_head_list.sv]
// A request that yields a result moves the controller to S_POP; the pop then loads the
// result into the output register, and is held off while that register is stalled.
// The input stalls from acceptance until that pop (accept, then pop) when a result is due;
// fill-phase requests without a result do not stall the input.
// Synchronous active-low reset empties the list, clears fill and step counters
// and loads register defaults (8 streams, all-ones limits); no clearing pass.
module kway_merge_head_list #(
    parameter int MAX_STREAMS = kmh_pkg::MAX_STREAMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  kmh_pkg::t_in_item                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output kmh_pkg::t_out_item                o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [kmh_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kmh_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import kmh_pkg::*;

    logic [SCOUNT_W-1:0]     r_stream_count;
    logic [BYTE_LIMIT_W-1:0] r_byte_limit;
    logic [ROW_LIMIT_W-1:0]  r_row_limit;
    t_dp_cmd                 cmd;
    t_dp_status              status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_count <= STREAM_COUNT_RST;
            r_byte_limit   <= BYTE_LIMIT_RST;
            r_row_limit    <= ROW_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STREAM_COUNT:    r_stream_count <= i_cfg_data[SCOUNT_W-1:0];
                CFG_STEP_BYTE_LIMIT: r_byte_limit   <= i_cfg_data[BYTE_LIMIT_W-1:0];
                CFG_STEP_ROW_LIMIT:  r_row_limit    <= i_cfg_data[ROW_LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    kmh_ctrl #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_run_ended    (i_in.run_ended),
        .o_in_stall     (o_in_stall),
        .i_stream_count (r_stream_count),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    kmh_datapath #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_in),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_byte_limit (r_byte_limit),
        .i_row_limit  (r_row_limit),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

endmodule

[sv/kmh_checker.sv]
// Port-level checker for the k-way merge head list, bound to the top level.
// Depends on kmh_pkg and kway_merge_head_list.
module kmh_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input kmh_pkg::t_out_item o_out
);
    import kmh_pkg::*;

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.result_kind == KIND_END) |->
            (o_out.winner_stream == '0) && (o_out.winner_key == '0) &&
            (o_out.winner_length == '0) && !o_out.step_done)
        else $error("end-of-run result carries nonzero fields");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_result_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pop cycle");

endmodule

bind kway_merge_head_list kmh_checker u_kmh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[bench/kway_merge_head_list_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for kway_merge_head_list: directed table plus mostly well-formed random merge runs,
// with random idling on both channels and an output hold-off.
// Depends on kmh_pkg and the kway_merge_head_list RTL.
module kway_merge_head_list_tb;
    import kmh_pkg::*;

    localparam int HOLD_CYCLES    = 500;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 2000;

    typedef struct {
        bit                      is_cfg;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   data;
        t_in_item                req;
        bit                      pinned;
        t_out_item               want;
    } t_plan_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    t_in_item                 i_in;
    logic                     o_out_valid;
    logic                     i_out_stall;
    t_out_item                o_out;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_INDEX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    // merge predictor state
    logic [KEY_WIDTH-1:0]     heads_key [MAX_STREAMS_DEF];
    logic [SRC_W-1:0]         heads_src [MAX_STREAMS_DEF];
    logic [LEN_W-1:0]         heads_len [MAX_STREAMS_DEF];
    int                       heads_n;
    int                       fill_seen;
    bit                       merge_on;
    logic [BYTE_LIMIT_W-1:0]  step_bytes;
    logic [ROW_LIMIT_W-1:0]   step_rows;
    logic [SCOUNT_W-1:0]      streams_cfg;
    logic [BYTE_LIMIT_W-1:0]  byte_lim_cfg;
    logic [ROW_LIMIT_W-1:0]   row_lim_cfg;
    logic [SRC_W-1:0]         last_win;

    t_out_item                pending_results[$];
    t_plan_row                plan_q[$];
    bit                       pin_on;
    t_out_item                pin_val;

    logic [KEY_WIDTH-1:0]     run_key [MAX_STREAMS_DEF];
    int                       run_left [MAX_STREAMS_DEF];
    bit                       run_dense;

    int                       fail_count;
    int                       requests_seen;
    int                       results_seen;
    int                       end_marks;
    int                       cfg_writes;
    int                       idle_cycles;

    kway_merge_head_list u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic merge_predict(input t_in_item rq, output bit hit, output t_out_item res);
        int eff;
        int pos;
        int k;
        logic [BYTE_LIMIT_W:0] bsum;
        logic [ROW_LIMIT_W:0]  rsum;
        bit done;
        eff = int'(streams_cfg);
        if (eff == 0) eff = 1;
        if (eff > MAX_STREAMS_DEF) eff = MAX_STREAMS_DEF;
        hit = 1'b1;
        res = '0;
        if (!rq.run_ended && heads_n < MAX_STREAMS_DEF) begin
            pos = 0;
            while (pos < heads_n && heads_key[pos] < rq.sort_key) pos++;
            for (k = heads_n; k > pos; k--) begin
                heads_key[k] = heads_key[k-1];
                heads_src[k] = heads_src[k-1];
                heads_len[k] = heads_len[k-1];
            end
            heads_key[pos] = rq.sort_key;
            heads_src[pos] = rq.source_stream;
            heads_len[pos] = rq.record_length;
            heads_n++;
        end
        if (!merge_on) begin
            fill_seen++;
            if (fill_seen < eff) begin
                hit = 1'b0;
            end else begin
                fill_seen = 0;
                merge_on  = 1'b1;
            end
        end
        if (hit) begin
            if (heads_n == 0) begin
                merge_on        = 1'b0;
                step_bytes      = '0;
                step_rows       = '0;
                res.result_kind = KIND_END;
            end else begin
                res.result_kind   = KIND_RECORD;
                res.winner_stream = heads_src[0];
                res.winner_key    = heads_key[0];
                res.winner_length = heads_len[0];
                bsum = {1'b0, step_bytes} + (BYTE_LIMIT_W+1)'(heads_len[0]);
                rsum = {1'b0, step_rows} + (ROW_LIMIT_W+1)'(1);
                done = (bsum >= {1'b0, byte_lim_cfg}) || (rsum >= {1'b0, row_lim_cfg});
                if (done) begin
                    step_bytes = '0;
                    step_rows  = '0;
                end else begin
                    step_bytes = bsum[BYTE_LIMIT_W-1:0];
                    step_rows  = rsum[ROW_LIMIT_W-1:0];
                end
                res.step_done = done;
                for (k = 1; k < heads_n; k++) begin
                    heads_key[k-1] = heads_key[k];
                    heads_src[k-1] = heads_src[k];
                    heads_len[k-1] = heads_len[k];
                end
                heads_n--;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit        hit;
        if (!i_rst_n) begin
            heads_n       = 0;
            fill_seen     = 0;
            merge_on      = 1'b0;
            step_bytes    = '0;
            step_rows     = '0;
            streams_cfg   = STREAM_COUNT_RST;
            byte_lim_cfg  = BYTE_LIMIT_RST;
            row_lim_cfg   = ROW_LIMIT_RST;
            last_win      = '0;
            fail_count    = 0;
            requests_seen = 0;
            results_seen  = 0;
            end_marks     = 0;
            cfg_writes    = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_STREAM_COUNT:    streams_cfg  = i_cfg_data[SCOUNT_W-1:0];
                    CFG_STEP_BYTE_LIMIT: byte_lim_cfg = i_cfg_data[BYTE_LIMIT_W-1:0];
                    CFG_STEP_ROW_LIMIT:  row_lim_cfg  = i_cfg_data[ROW_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (o_out.result_kind === KIND_END) end_marks++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: %p", o_out);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %h, got %h",
                               want.result_kind, o_out.result_kind);
                        fail_count++;
                    end
                    if (o_out.winner_stream !== want.winner_stream) begin
                        $error("winner_stream: expected %h, got %h",
                               want.winner_stream, o_out.winner_stream);
                        fail_count++;
                    end
                    if (o_out.winner_key !== want.winner_key) begin
                        $error("winner_key: expected %h, got %h",
                               want.winner_key, o_out.winner_key);
                        fail_count++;
                    end
                    if (o_out.winner_length !== want.winner_length) begin
                        $error("winner_length: expected %h, got %h",
                               want.winner_length, o_out.winner_length);
                        fail_count++;
                    end
                    if (o_out.step_done !== want.step_done) begin
                        $error("step_done: expected %h, got %h",
                               want.step_done, o_out.step_done);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                requests_seen++;
                merge_predict(i_in, hit, want);
                if (hit) begin
                    if (want.result_kind == KIND_RECORD) last_win = want.winner_stream;
                    if (pin_on) want = pin_val;
                    pending_results.push_back(want);
                end else if (pin_on) begin
                    $error("request %p gave no result, one was listed", i_in);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // output side: random stalls per result, one long hold-off
    initial begin
        int  rx_wait;
        int  got;
        bit  held;
        got  = 0;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            if (((got / 64) % 4) == 1) rx_wait = 0;
            else rx_wait = $urandom_range(0, 13);
            if (got == 300 && !held) begin
                rx_wait = HOLD_CYCLES;
                held    = 1'b1;
            end
            @(negedge i_clk);
            if (rx_wait > 0) begin
                i_out_stall <= 1'b1;
                repeat (rx_wait) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got++;
        end
    end

    // call at a falling edge; returns at the rising edge that takes the request
    task automatic push_request(input t_in_item rq, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= rq;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drop_request();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        plan_q.push_back(r);
    endfunction

    function automatic void add_req(input int src, input bit ended,
                                    input logic [31:0] key, input logic [15:0] len);
        t_plan_row r;
        r = '{default: '0};
        r.req.source_stream = src[SRC_W-1:0];
        r.req.run_ended     = ended;
        r.req.sort_key      = key;
        r.req.record_length = len;
        plan_q.push_back(r);
    endfunction

    function automatic void add_pin(input int src, input bit ended, input logic [31:0] key,
                                    input logic [15:0] len, input logic kind, input int wsrc,
                                    input logic [31:0] wkey, input logic [15:0] wlen,
                                    input bit done);
        add_req(src, ended, key, len);
        plan_q[$].pinned             = 1'b1;
        plan_q[$].want.result_kind   = kind;
        plan_q[$].want.winner_stream = wsrc[SRC_W-1:0];
        plan_q[$].want.winner_key    = wkey;
        plan_q[$].want.winner_length = wlen;
        plan_q[$].want.step_done     = done;
    endfunction

    task automatic open_streams();
        int s;
        run_dense = ($urandom_range(0, 3) == 0);
        for (s = 0; s < MAX_STREAMS_DEF; s++) begin
            run_left[s] = $urandom_range(0, 6);
            if (run_dense) run_key[s] = $urandom_range(0, 3);
            else if ($urandom_range(0, 3) == 0) run_key[s] = $urandom_range(0, 255);
            else if ($urandom_range(0, 2) == 0) run_key[s] = 32'hFFFF_FF00 | $urandom_range(0, 255);
            else run_key[s] = $urandom;
        end
    endtask

    // mostly the next record of the stream that must refill, some noise
    task automatic next_stream_request(output t_in_item rq);
        int s;
        logic [KEY_WIDTH-1:0] stepv;
        if ($urandom_range(0, 9) == 0) begin
            rq.source_stream = SRC_W'($urandom_range(0, 7));
            rq.run_ended     = 1'($urandom_range(0, 1));
            rq.sort_key      = $urandom;
            rq.record_length = LEN_W'($urandom_range(0, 65535));
        end else begin
            if (!merge_on) begin
                if (fill_seen == 0) open_streams();
                s = fill_seen % MAX_STREAMS_DEF;
            end else begin
                s = int'(last_win);
            end
            rq.source_stream = s[SRC_W-1:0];
            if (run_left[s] == 0) begin
                rq.run_ended     = 1'b1;
                rq.sort_key      = $urandom;
                rq.record_length = LEN_W'($urandom_range(0, 65535));
            end else begin
                run_left[s]--;
                rq.run_ended     = 1'b0;
                rq.sort_key      = run_key[s];
                if ($urandom_range(0, 3) == 0) rq.record_length = LEN_W'($urandom_range(1, 16));
                else rq.record_length = LEN_W'($urandom_range(1, 65535));
                stepv = run_dense ? $urandom_range(0, 1) : $urandom_range(0, 32'h00FF_FFFF);
                run_key[s] = (run_key[s] > ~stepv) ? '1 : run_key[s] + stepv;
            end
        end
    endtask

    initial begin
        t_in_item rq;
        int       n;
        int       phase_left;
        logic [SCOUNT_W-1:0]     sc;
        logic [BYTE_LIMIT_W-1:0] bl;
        logic [ROW_LIMIT_W-1:0]  rl;
        pin_on        = 1'b0;
        pin_val       = '0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;

        // three streams, equal keys, row limit of two, key and length extremes
        add_cfg(CFG_STREAM_COUNT, 3);
        add_cfg(CFG_STEP_ROW_LIMIT, 2);
        add_req(0, 0, 32'h10, 16'd5);
        add_req(1, 0, 32'hFFFF_FFFF, 16'hFFFF);
        add_pin(2, 0, 32'h10, 16'd1, KIND_RECORD, 2, 32'h10, 16'd1, 1'b0);
        add_pin(2, 1, 32'h0, 16'd0, KIND_RECORD, 0, 32'h10, 16'd5, 1'b1);
        add_pin(0, 1, 32'h0, 16'd0, KIND_RECORD, 1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_pin(1, 1, 32'h0, 16'd0, KIND_END, 0, 32'h0, 16'd0, 1'b0);
        // stream count zero, byte limit zero, zero length, a run ended at fill
        add_cfg(CFG_STREAM_COUNT, 0);
        add_cfg(CFG_STEP_BYTE_LIMIT, 0);
        add_pin(7, 0, 32'h0, 16'd0, KIND_RECORD, 7, 32'h0, 16'd0, 1'b1);
        add_pin(7, 1, 32'hFFFF_FFFF, 16'hFFFF, KIND_END, 0, 32'h0, 16'd0, 1'b0);
        add_pin(3, 1, 32'h5555_5555, 16'h1234, KIND_END, 0, 32'h0, 16'd0, 1'b0);
        // stream count above the maximum, full list, refill from another stream
        add_cfg(CFG_STREAM_COUNT, 15);
        add_cfg(CFG_STEP_BYTE_LIMIT, 32'hFFFF_FFFF);
        add_cfg(CFG_STEP_ROW_LIMIT, 32'h0000_FFFF);
        add_req(0, 0, 32'h8000_0000, 16'd100);
        add_req(1, 0, 32'h0000_0001, 16'd200);
        add_req(2, 0, 32'hFFFF_FFFF, 16'd1);
        add_req(3, 0, 32'h0000_0001, 16'd300);
        add_req(4, 0, 32'h7FFF_FFFF, 16'hFFFF);
        add_req(5, 0, 32'h0000_0000, 16'd7);
        add_req(6, 0, 32'h0000_0002, 16'd50);
        add_req(7, 0, 32'h1234_5678, 16'hFFFF);
        add_req(5, 0, 32'h0000_0010, 16'd9);
        add_req(2, 0, 32'h0000_0000, 16'h8000);
        add_req(3, 1, 32'h0, 16'd1);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan_q[k]) begin
            if (plan_q[k].is_cfg) begin
                drop_request();
                settle();
                cfg_write(plan_q[k].idx, plan_q[k].data);
            end else begin
                @(negedge i_clk);
                pin_on  = plan_q[k].pinned;
                pin_val = plan_q[k].want;
                push_request(plan_q[k].req, 1'b0);
            end
        end
        @(negedge i_clk);
        pin_on = 1'b0;

        phase_left = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                drop_request();
                settle();
                case ($urandom_range(0, 5))
                    0:       sc = '0;
                    1:       sc = SCOUNT_W'(8);
                    2:       sc = SCOUNT_W'($urandom_range(9, 15));
                    default: sc = SCOUNT_W'($urandom_range(1, 8));
                endcase
                case ($urandom_range(0, 4))
                    0:       bl = $urandom_range(0, 1);
                    1:       bl = '1;
                    2:       bl = $urandom;
                    default: bl = $urandom_range(1, 400000);
                endcase
                case ($urandom_range(0, 3))
                    0:       rl = ROW_LIMIT_W'($urandom_range(0, 1));
                    1:       rl = '1;
                    default: rl = ROW_LIMIT_W'($urandom_range(2, 24));
                endcase
                cfg_write(CFG_STREAM_COUNT, CFG_DATA_W'(sc));
                cfg_write(CFG_STEP_BYTE_LIMIT, bl);
                cfg_write(CFG_STEP_ROW_LIMIT, CFG_DATA_W'(rl));
                phase_left = $urandom_range(120, 260);
            end
            @(negedge i_clk);
            next_stream_request(rq);
            push_request(rq, ((n / 64) % 4) == 3);
            phase_left--;
        end
        drop_request();
        settle();

        $display("run covered %0d requests, %0d results (%0d end-of-run), %0d register writes,",
                 requests_seen, results_seen, end_marks, cfg_writes);
        $display("with random idling on both sides and a %0d-cycle output hold-off", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
